>>> rtl/core/ngll_pkg.sv
// Shared types, constants and helper functions of the GLL position parser.
`default_nettype none

package ngll_pkg;

  // Field widths of the result transaction, of a character and of a digit.
  localparam int unsigned INT_W   = 17;
  localparam int unsigned FRAC_W  = 30;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  // Saturation limits of the decimal accumulators.
  localparam int unsigned FRAC_DIGITS_MAX = 9;
  localparam int unsigned INT_PART_MAX    = 99999;

  // Widths of the multiply-by-ten sums before saturation or masking.
  localparam int unsigned INT_SUM_W  = INT_W + 4;
  localparam int unsigned FRAC_SUM_W = FRAC_W + 4;

  // Header tracking and field counting.
  localparam int unsigned PROG_W  = 3;
  localparam int unsigned FIELD_W = 3;
  localparam logic [PROG_W-1:0]  HDR_LEN   = 3'd6;
  localparam logic [FIELD_W-1:0] LAT_FIELD = 3'd1;
  localparam logic [FIELD_W-1:0] LON_FIELD = 3'd3;
  localparam logic [FIELD_W-1:0] FIELD_SAT = 3'd7;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_NEWLINE = 8'h0A;
  localparam char_t CH_POINT   = 8'h2E;
  localparam char_t CH_COMMA   = 8'h2C;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_NINE    = 8'h39;
  localparam char_t CH_DOLLAR  = 8'h24;
  localparam char_t CH_G       = 8'h47;
  localparam char_t CH_N       = 8'h4E;
  localparam char_t CH_L       = 8'h4C;

  // One decoded coordinate: integer part, fraction digits and their count.
  typedef struct packed {
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac_part;
    logic [CNT_W-1:0]  frac_digits;
  } coord_t;

  typedef struct packed {
    coord_t lat;
    coord_t lon;
    logic   overflow;
  } result_t;

  // Coordinate after one digit, plus whether that digit saturated or was dropped.
  typedef struct packed {
    coord_t coord;
    logic   ovf;
  } coord_step_t;

  // Handshake between the line tracker and the output register.
  typedef struct packed {
    logic    load;
    result_t result;
  } result_req_t;

  // Expected character of the "$GNGLL" header at a given match position.
  function automatic char_t hdr_char(input logic [PROG_W-1:0] pos);
    char_t c;
    unique case (pos)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = CH_G;
      3'd2:    c = CH_N;
      3'd3:    c = CH_G;
      3'd4:    c = CH_L;
      3'd5:    c = CH_L;
      default: c = CH_L;
    endcase
    return c;
  endfunction

  // Folds one decimal digit into a coordinate.
  function automatic coord_step_t add_digit(input coord_t c, input logic after_point,
                                            input logic [DIGIT_W-1:0] d);
    coord_step_t            s;
    logic [INT_SUM_W-1:0]   int_ext;
    logic [INT_SUM_W-1:0]   int_sum;
    logic [FRAC_SUM_W-1:0]  frac_ext;
    logic [FRAC_SUM_W-1:0]  frac_sum;
    int_ext  = {{(INT_SUM_W-INT_W){1'b0}}, c.int_part};
    int_sum  = (int_ext << 3) + (int_ext << 1) + {{(INT_SUM_W-DIGIT_W){1'b0}}, d};
    frac_ext = {{(FRAC_SUM_W-FRAC_W){1'b0}}, c.frac_part};
    frac_sum = (frac_ext << 3) + (frac_ext << 1) + {{(FRAC_SUM_W-DIGIT_W){1'b0}}, d};
    s.coord  = c;
    s.ovf    = 1'b0;
    if (!after_point) begin
      if (int_sum > INT_SUM_W'(INT_PART_MAX)) begin
        s.coord.int_part = INT_W'(INT_PART_MAX);
        s.ovf            = 1'b1;
      end else begin
        s.coord.int_part = int_sum[INT_W-1:0];
      end
    end else if (c.frac_digits < CNT_W'(FRAC_DIGITS_MAX)) begin
      s.coord.frac_part   = frac_sum[FRAC_W-1:0];
      s.coord.frac_digits = c.frac_digits + 1'b1;
    end else begin
      s.ovf = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ngll_if.sv
// Valid/ready channel interfaces for received characters and decoded positions.
`default_nettype none

interface ngll_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ngll_result_if;
  logic        valid;
  logic        ready;
  logic [16:0] lat_int;
  logic [29:0] lat_frac;
  logic [3:0]  lat_frac_digits;
  logic [16:0] lon_int;
  logic [29:0] lon_frac;
  logic [3:0]  lon_frac_digits;
  logic        overflow;

  modport source (output valid, output lat_int, output lat_frac, output lat_frac_digits,
                  output lon_int, output lon_frac, output lon_frac_digits,
                  output overflow, input ready);
  modport sink   (input valid, input lat_int, input lat_frac, input lat_frac_digits,
                  input lon_int, input lon_frac, input lon_frac_digits,
                  input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ngll_in_stage.sv
// Input register holding one received character until the line tracker takes it.
`default_nettype none

module ngll_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire ngll_pkg::char_t in_char,
  output logic                in_ready,
  input  wire logic           take,
  output logic                char_valid,
  output ngll_pkg::char_t     char_out
);

  logic            valid_r;
  logic            valid_nxt;
  ngll_pkg::char_t char_r;

  assign in_ready   = !valid_r || take;
  assign char_valid = valid_r;
  assign char_out   = char_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ngll_line_tracker.sv
// Per-line state: header match, field counting and decimal accumulation.
`default_nettype none

module ngll_line_tracker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              char_valid,
  input  wire ngll_pkg::char_t   char_in,
  input  wire logic              out_free,
  output logic                   take,
  output ngll_pkg::result_req_t  req
);

  logic [ngll_pkg::PROG_W-1:0]  hdr_prog_r,   hdr_prog_nxt;
  logic                         hdr_seen_r,   hdr_seen_nxt;
  logic [ngll_pkg::FIELD_W-1:0] field_r,      field_nxt;
  logic                         after_pt_r,   after_pt_nxt;
  ngll_pkg::coord_t             lat_r,        lat_nxt;
  ngll_pkg::coord_t             lon_r,        lon_nxt;
  logic                         ovf_r,        ovf_nxt;

  logic                          is_newline;
  logic                          is_digit;
  logic [ngll_pkg::DIGIT_W-1:0]  digit;
  ngll_pkg::coord_step_t         lat_step;
  ngll_pkg::coord_step_t         lon_step;
  ngll_pkg::char_t               digit_full;

  assign is_newline = (char_in == ngll_pkg::CH_NEWLINE);
  assign is_digit   = (char_in >= ngll_pkg::CH_ZERO) && (char_in <= ngll_pkg::CH_NINE);
  assign digit_full = char_in - ngll_pkg::CH_ZERO;
  assign digit      = digit_full[ngll_pkg::DIGIT_W-1:0];
  assign lat_step   = ngll_pkg::add_digit(lat_r, after_pt_r, digit);
  assign lon_step   = ngll_pkg::add_digit(lon_r, after_pt_r, digit);

  // A newline on a matched line needs the output register; anything else never stalls.
  assign take = char_valid && (!(is_newline && hdr_seen_r) || out_free);

  always_comb begin
    req.load            = take && is_newline && hdr_seen_r;
    req.result.lat      = lat_r;
    req.result.lon      = lon_r;
    req.result.overflow = ovf_r;
  end

  always_comb begin
    hdr_prog_nxt = hdr_prog_r;
    hdr_seen_nxt = hdr_seen_r;
    field_nxt    = field_r;
    after_pt_nxt = after_pt_r;
    lat_nxt      = lat_r;
    lon_nxt      = lon_r;
    ovf_nxt      = ovf_r;
    if (take) begin
      if (is_newline) begin
        hdr_prog_nxt = '0;
        hdr_seen_nxt = 1'b0;
        field_nxt    = '0;
        after_pt_nxt = 1'b0;
        lat_nxt      = '0;
        lon_nxt      = '0;
        ovf_nxt      = 1'b0;
      end else begin
        // Header search restarts on a mismatch; a dollar sign reopens it.
        if (hdr_prog_r < ngll_pkg::HDR_LEN && char_in == ngll_pkg::hdr_char(hdr_prog_r)) begin
          if (hdr_prog_r + 1'b1 == ngll_pkg::HDR_LEN) begin
            hdr_seen_nxt = 1'b1;
            hdr_prog_nxt = '0;
          end else begin
            hdr_prog_nxt = hdr_prog_r + 1'b1;
          end
        end else if (char_in == ngll_pkg::CH_DOLLAR) begin
          hdr_prog_nxt = ngll_pkg::PROG_W'(1);
        end else begin
          hdr_prog_nxt = '0;
        end

        if (char_in == ngll_pkg::CH_COMMA) begin
          if (field_r != ngll_pkg::FIELD_SAT) begin
            field_nxt = field_r + 1'b1;
          end
          after_pt_nxt = 1'b0;
        end else if (char_in == ngll_pkg::CH_POINT) begin
          if (field_r == ngll_pkg::LAT_FIELD || field_r == ngll_pkg::LON_FIELD) begin
            after_pt_nxt = 1'b1;
          end
        end else if (is_digit) begin
          if (field_r == ngll_pkg::LAT_FIELD) begin
            lat_nxt = lat_step.coord;
            ovf_nxt = ovf_r || lat_step.ovf;
          end else if (field_r == ngll_pkg::LON_FIELD) begin
            lon_nxt = lon_step.coord;
            ovf_nxt = ovf_r || lon_step.ovf;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_prog_r <= '0;
      hdr_seen_r <= 1'b0;
      field_r    <= '0;
      after_pt_r <= 1'b0;
      lat_r      <= '0;
      lon_r      <= '0;
      ovf_r      <= 1'b0;
    end else begin
      hdr_prog_r <= hdr_prog_nxt;
      hdr_seen_r <= hdr_seen_nxt;
      field_r    <= field_nxt;
      after_pt_r <= after_pt_nxt;
      lat_r      <= lat_nxt;
      lon_r      <= lon_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ngll_out_stage.sv
// Output register holding one decoded position until the sink takes it.
`default_nettype none

module ngll_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ngll_pkg::result_req_t req,
  output logic                       out_free,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ngll_pkg::result_t          out_result
);

  logic              valid_r;
  logic              valid_nxt;
  ngll_pkg::result_t result_r;

  assign out_free   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (req.load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      result_r <= req.result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nmea_gll_position_parser_core.sv
// A character taken into the input register is then folded into the line tracker's state.
// A newline on a "$GNGLL" line loads its position transaction into the output register,
// from which the transaction leaves once the sink is ready.
// Throughput: one character per cycle, set by the line tracker, which updates for each one.
// The tracker stalls only when a newline must load a still-occupied output register.
// Reset (rst_n low, synchronous) empties both registers and clears all line state.
`default_nettype none

module nmea_gll_position_parser_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ngll_byte_if.sink   in_byte,
  ngll_result_if.source out_pos
);

  // Character held between the input register and the line tracker.
  logic            char_valid;
  ngll_pkg::char_t char_held;
  logic            take;

  // Result request from the tracker and room in the output register.
  ngll_pkg::result_req_t req;
  logic                  out_free;
  ngll_pkg::result_t     out_result;

  // The input register frees as the tracker takes its character, so a new character
  // can be taken while a finished position still waits, unless a matched newline is held.
  ngll_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_byte.valid),
    .in_char    (in_byte.data_byte),
    .in_ready   (in_byte.ready),
    .take       (take),
    .char_valid (char_valid),
    .char_out   (char_held)
  );

  // Header search, comma counting and the multiply-by-ten accumulators. Every
  // character except a newline on a matched line is consumed unconditionally.
  ngll_line_tracker u_line_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_in    (char_held),
    .out_free   (out_free),
    .take       (take),
    .req        (req)
  );

  // The output register is reloaded in the same cycle that its previous
  // transaction leaves, so back-to-back newlines still run at full rate.
  ngll_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .out_free   (out_free),
    .out_valid  (out_pos.valid),
    .out_ready  (out_pos.ready),
    .out_result (out_result)
  );

  assign out_pos.lat_int         = out_result.lat.int_part;
  assign out_pos.lat_frac        = out_result.lat.frac_part;
  assign out_pos.lat_frac_digits = out_result.lat.frac_digits;
  assign out_pos.lon_int         = out_result.lon.int_part;
  assign out_pos.lon_frac        = out_result.lon.frac_part;
  assign out_pos.lon_frac_digits = out_result.lon.frac_digits;
  assign out_pos.overflow        = out_result.overflow;

endmodule

`default_nettype wire

>>> tb/sv/nmea_gll_position_checker.sv
`timescale 1ns / 1ps
// Checker that predicts decoded GLL positions and compares them with the parser's output.
module nmea_gll_position_checker (
  input  logic   clk,
  input  logic   rst_n,
  ngll_byte_if   in_mon,
  ngll_result_if out_mon,
  output int     mismatch_count,
  output int     positions_pending
);
  import ngll_pkg::*;

  localparam logic [47:0] GLL_HEADER = {CH_DOLLAR, CH_G, CH_N, CH_G, CH_L, CH_L};

  // Line state of the predictor.
  logic [PROG_W-1:0]  hdr_pos;
  logic               hdr_found;
  logic [FIELD_W-1:0] comma_count;
  logic               in_fraction;
  coord_t             lat_acc;
  coord_t             lon_acc;
  logic               digits_lost;

  result_t positions_due[$];
  int      fail_total;

  function automatic coord_t coord_with_digit(input coord_t c, input logic [DIGIT_W-1:0] d);
    coord_t          nxt;
    int unsigned     widened;
    longint unsigned frac_wide;
    nxt = c;
    if (!in_fraction) begin
      widened = int'(c.int_part) * 10 + d;
      if (widened > INT_PART_MAX) begin
        nxt.int_part = INT_W'(INT_PART_MAX);
        digits_lost  = 1'b1;
      end else begin
        nxt.int_part = widened[INT_W-1:0];
      end
    end else if (c.frac_digits < FRAC_DIGITS_MAX) begin
      frac_wide       = longint'(c.frac_part) * 10 + d;
      nxt.frac_part   = frac_wide[FRAC_W-1:0];
      nxt.frac_digits = c.frac_digits + 1'b1;
    end else begin
      digits_lost = 1'b1;
    end
    return nxt;
  endfunction

  function automatic void clear_line_state();
    hdr_pos     = '0;
    hdr_found   = 1'b0;
    comma_count = '0;
    in_fraction = 1'b0;
    lat_acc     = '0;
    lon_acc     = '0;
    digits_lost = 1'b0;
  endfunction

  function automatic void fold_char(input char_t c);
    result_t r;
    if (c == CH_NEWLINE) begin
      if (hdr_found) begin
        r.lat      = lat_acc;
        r.lon      = lon_acc;
        r.overflow = digits_lost;
        positions_due.push_back(r);
      end
      clear_line_state();
    end else begin
      if (hdr_pos < HDR_LEN && c == GLL_HEADER[47 - 8 * int'(hdr_pos) -: 8]) begin
        hdr_pos = hdr_pos + 1'b1;
        if (hdr_pos == HDR_LEN) begin
          hdr_found = 1'b1;
          hdr_pos   = '0;
        end
      end else begin
        hdr_pos = (c == CH_DOLLAR) ? PROG_W'(1) : '0;
      end
      if (c == CH_COMMA) begin
        if (comma_count != FIELD_SAT) comma_count = comma_count + 1'b1;
        in_fraction = 1'b0;
      end else if (c == CH_POINT) begin
        if (comma_count == LAT_FIELD || comma_count == LON_FIELD) in_fraction = 1'b1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        if (comma_count == LAT_FIELD) begin
          lat_acc = coord_with_digit(lat_acc, DIGIT_W'(c - CH_ZERO));
        end else if (comma_count == LON_FIELD) begin
          lon_acc = coord_with_digit(lon_acc, DIGIT_W'(c - CH_ZERO));
        end
      end
    end
  endfunction

  function automatic void check_position();
    result_t got;
    result_t want;
    logic    bad;
    got.lat.int_part    = out_mon.lat_int;
    got.lat.frac_part   = out_mon.lat_frac;
    got.lat.frac_digits = out_mon.lat_frac_digits;
    got.lon.int_part    = out_mon.lon_int;
    got.lon.frac_part   = out_mon.lon_frac;
    got.lon.frac_digits = out_mon.lon_frac_digits;
    got.overflow        = out_mon.overflow;
    if (positions_due.size() == 0) begin
      fail_total++;
      if (fail_total <= 10)
        $display("%0t: position transaction with none expected: lat %0d.%0d/%0d lon %0d.%0d/%0d ovf %0d",
                 $time, got.lat.int_part, got.lat.frac_part, got.lat.frac_digits,
                 got.lon.int_part, got.lon.frac_part, got.lon.frac_digits, got.overflow);
    end else begin
      want = positions_due.pop_front();
      bad  = (got.lat.int_part !== want.lat.int_part) ||
             (got.lat.frac_part !== want.lat.frac_part) ||
             (got.lat.frac_digits !== want.lat.frac_digits) ||
             (got.lon.int_part !== want.lon.int_part) ||
             (got.lon.frac_part !== want.lon.frac_part) ||
             (got.lon.frac_digits !== want.lon.frac_digits) ||
             (got.overflow !== want.overflow);
      if (bad) begin
        fail_total++;
        if (fail_total <= 10) begin
          $display("%0t: position mismatch", $time);
          $display("  expected lat %0d.%0d/%0d lon %0d.%0d/%0d ovf %0d",
                   want.lat.int_part, want.lat.frac_part, want.lat.frac_digits,
                   want.lon.int_part, want.lon.frac_part, want.lon.frac_digits, want.overflow);
          $display("  actual   lat %0d.%0d/%0d lon %0d.%0d/%0d ovf %0d",
                   got.lat.int_part, got.lat.frac_part, got.lat.frac_digits,
                   got.lon.int_part, got.lon.frac_part, got.lon.frac_digits, got.overflow);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line_state();
      positions_due.delete();
      fail_total = 0;
    end else begin
      // A result leaves only after its newline has passed the input and output registers, so
      // it is checked before the character taken at this same edge is folded in.
      if (out_mon.valid && out_mon.ready) begin
        check_position();
      end
      if (in_mon.valid && in_mon.ready) fold_char(in_mon.data_byte);
    end
    mismatch_count    <= fail_total;
    positions_pending <= positions_due.size();
  end

endmodule

>>> tb/sv/nmea_gll_position_parser_core_test.sv
`timescale 1ns / 1ps
// Top of the GLL position parser testbench: clock, reset, sentence stimulus and verdict.
module nmea_gll_position_parser_core_test;
  import ngll_pkg::*;

  // The random part stops once this many characters have gone in; the tail
  // of the run is free of idling.
  localparam int unsigned ITEM_TARGET   = 1600;
  localparam int unsigned QUIET_FROM    = 1300;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // The long receiver hold-off starts soon after reset, while the directed
  // sentences are still flowing, so that the output register fills and the
  // parser has to stall its input.
  localparam int unsigned HOLD_START    = 100;
  localparam int unsigned HOLD_CYCLES   = 500;

  logic clk;
  logic rst_n = 1'b0;

  ngll_byte_if   in_ch ();
  ngll_result_if out_ch ();

  int mismatch_total;
  int positions_left;

  int unsigned accepted_bytes = 0;
  bit          quiet_tail     = 1'b0;
  bit          sender_gappy   = 1'b0;
  char_t       line_buf[$];

  nmea_gll_position_parser_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_ch),
    .out_pos (out_ch)
  );

  nmea_gll_position_checker position_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .mismatch_count    (mismatch_total),
    .positions_pending (positions_left)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The watchdog ends a run that hangs, for instance when the parser never
  // produces a position that the checker is waiting for.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver decides its ready once per falling edge. It stalls in random
  // bursts, has calm stretches without new random stalls, and holds off once
  // for a long stretch. Near the end it always accepts.
  initial begin : receiver
    int unsigned cycle_no;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          calm;
    cycle_no   = 0;
    stall_left = 0;
    hold_left  = 0;
    calm       = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (cycle_no == HOLD_START) hold_left = HOLD_CYCLES;
      if (cycle_no % 256 == 0) calm = ($urandom_range(0, 2) == 0);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_tail && !calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
      cycle_no++;
      @(negedge clk);
    end
  end

  // Offers one character and returns at the falling edge after its transaction.
  // A gap, where one is taken, lowers valid at that same falling edge, so valid
  // never gets two updates in one time step.
  task automatic send_byte(input char_t b);
    if (!quiet_tail && sender_gappy && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accepted_bytes++;
    @(negedge clk);
  endtask

  task automatic send_buffered();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(char_t'(s[i]));
  endfunction

  task automatic send_text(input string s);
    put_text(s);
    send_buffered();
  endtask

  function automatic void put_digits(input int n);
    for (int i = 0; i < n; i++) line_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
  endfunction

  function automatic void put_noise(input int n);
    for (int i = 0; i < n; i++) line_buf.push_back(char_t'($urandom_range(0, 255)));
  endfunction

  // Mostly the usual length of a field, sometimes anything up to the given
  // maximum, which is long enough to saturate or to drop fraction digits.
  function automatic int pick_len(input int usual, input int most);
    if ($urandom_range(0, 4) != 0) return usual;
    return $urandom_range(0, most);
  endfunction

  function automatic void put_coord(input int usual_int);
    put_digits(pick_len(usual_int, 7));
    if ($urandom_range(0, 9) != 0) begin
      line_buf.push_back(CH_POINT);
      put_digits(pick_len($urandom_range(1, 5), 11));
      // Now and then a second point, which must not restart the fraction.
      if ($urandom_range(0, 19) == 0) begin
        line_buf.push_back(CH_POINT);
        put_digits($urandom_range(0, 3));
      end
    end
  endfunction

  // A well-formed GLL sentence with random content; one in ten is cut short,
  // and half of those run straight on into the next line.
  task automatic send_gll_sentence();
    string hex_digits;
    int    cut;
    hex_digits = "0123456789ABCDEF";
    if ($urandom_range(0, 4) == 0) put_noise($urandom_range(1, 3));
    put_text("$GNGLL,");
    put_coord(4);
    if ($urandom_range(0, 1) != 0) put_text(",N,");
    else put_text(",S,");
    put_coord(5);
    if ($urandom_range(0, 1) != 0) put_text(",E,");
    else put_text(",W,");
    put_digits(6);
    line_buf.push_back(CH_POINT);
    put_digits(2);
    put_text(",A,A*");
    line_buf.push_back(char_t'(hex_digits[$urandom_range(0, 15)]));
    line_buf.push_back(char_t'(hex_digits[$urandom_range(0, 15)]));
    if ($urandom_range(0, 1) != 0) put_text("\r\n");
    else put_text("\n");
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, line_buf.size() - 1);
      line_buf = line_buf[0:cut-1];
      if ($urandom_range(0, 1) != 0) line_buf.push_back(CH_NEWLINE);
    end
    send_buffered();
  endtask

  // Another sentence type, whose header must not be taken for GLL.
  task automatic send_other_sentence();
    case ($urandom_range(0, 2))
      0:       put_text("$GPGLL,");
      1:       put_text("$GNRMC,");
      default: put_text("$GNGLA,");
    endcase
    put_coord(4);
    put_text(",N,");
    put_coord(5);
    put_text("\r\n");
    send_buffered();
  endtask

  // A header broken off part-way; sometimes a fresh '$' then completes a real one.
  task automatic send_broken_header();
    string hdr;
    int    k;
    hdr = "$GNGLL";
    k = $urandom_range(1, 5);
    for (int i = 0; i < k; i++) line_buf.push_back(char_t'(hdr[i]));
    if ($urandom_range(0, 1) != 0) begin
      line_buf.push_back(CH_DOLLAR);
      if ($urandom_range(0, 1) != 0) put_text("GNGLL");
    end else begin
      line_buf.push_back(char_t'($urandom_range(8'h41, 8'h5A)));
    end
    put_text(",");
    put_coord(4);
    put_text(",N,");
    put_coord(5);
    put_text("\n");
    send_buffered();
  endtask

  initial begin : stimulus
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sentences: zeros and the largest values that still fit, both
    // kinds of saturation, a field with no point, a second point, missing
    // fields, header restarts on '$' and on a mismatch, a header in mid-line,
    // commas beyond saturation, carriage return, other sentence types, an
    // empty line, odd bytes inside a number and two lines run together.
    send_text("$GNGLL,0.0,N,0.0,E\r\n");
    send_text("$GNGLL,99999.999999999,N,99999.999999999,W\n");
    send_text("$GNGLL,1234567.1234567890,S,100000.99999999999,E\n");
    send_text("$GNGLL,4916,N,12311,W\n");
    send_text("$GNGLL,12.3.4,N,5..6,E\n");
    send_text("$GNGLL\n");
    send_text("$GNGLL,4916.45\n");
    send_text("$$GNGLL,1.5,,2.5\n");
    send_text("$GNGL$GNGLL,7.25,N,8.5\n");
    send_text("xy,$GNGLL,3.5,N,4.75,E,,,,,,,,,12.3\r\n");
    send_text("$GPGLL,1.5,N,2.5,E\n");
    send_text("\n");
    send_text("$GNGLL,,.7,,\n");
    put_text("$GNGLL,1");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    put_text("2.5,N,3");
    line_buf.push_back(8'h80);
    put_text(".25\n");
    send_buffered();
    send_text("$GNGLL,5,N,6\nA$GNGLL,8,N,9\n");
    send_text("$GNGLLGNGLL,1,,2\n");

    // Random part: mostly well-formed sentences, the rest other sentence
    // types, raw noise (which also brings stray newlines) and broken headers.
    while (accepted_bytes < ITEM_TARGET) begin
      quiet_tail   = (accepted_bytes >= QUIET_FROM);
      sender_gappy = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 99)) inside
        [0:64]:  send_gll_sentence();
        [65:74]: send_other_sentence();
        [75:87]: begin
          put_noise($urandom_range(1, 24));
          send_buffered();
        end
        default: send_broken_header();
      endcase
    end

    // Let every expected position arrive, then wait before the verdict so that
    // anything unexpected can still show up.
    in_ch.valid <= 1'b0;
    while (positions_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_total == 0 && positions_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
